/* src/chc_pkg.sv */
// Shared types and constants of the coin hopper dispense controller.
package chc_pkg;

	localparam int CFG_TIMER_W = 16;
	localparam int COIN_W      = 8;
	localparam int DUR_W       = 32;

	localparam logic [CFG_TIMER_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_TIMER_W-1:0] JAM_RST      = 16'd3000;
	localparam logic [COIN_W-1:0]      MAX_COINS_RST = 8'd200;

	typedef enum logic [1:0] {
		REG_DEBOUNCE  = 2'd0,
		REG_JAM       = 2'd1,
		REG_MAX_COINS = 2'd2,
		REG_NONE      = 2'd3
	} reg_idx_e;

	typedef enum logic [1:0] {
		MODE_TICK = 2'd0,
		MODE_EDGE = 2'd1,
		MODE_REQ  = 2'd2,
		MODE_STOP = 2'd3
	} mode_e;

	typedef enum logic [2:0] {
		EV_ACK_OK  = 3'd0,
		EV_ACK_REJ = 3'd1,
		EV_COIN    = 3'd2,
		EV_DONE    = 3'd3,
		EV_FAIL    = 3'd4
	} event_e;

	typedef enum logic [2:0] {
		ERR_NONE  = 3'd0,
		ERR_BUSY  = 3'd1,
		ERR_COUNT = 3'd2,
		ERR_JAM   = 3'd3,
		ERR_STOP  = 3'd4
	} err_e;

	typedef struct packed {
		logic [CFG_TIMER_W-1:0] debounce_ticks;
		logic [CFG_TIMER_W-1:0] jam_timeout_ticks;
		logic [COIN_W-1:0]      max_coins;
	} cfg_t;

	typedef struct packed {
		event_e             event_res;
		logic               ack_for;
		err_e               error_code;
		logic [COIN_W-1:0]  dispensed;
		logic [COIN_W-1:0]  expected;
		logic [DUR_W-1:0]   sess_len;
		logic               motor_on;
		logic               last;
	} res_t;

	// Up to two results handed from the core to the result queue in one cycle.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

/* src/chc_cfg.sv */
// Configuration register file with its APB-style access port.
module chc_cfg
	import chc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t     cfg_q;
	reg_idx_e idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_e'(paddr[3:2]);
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks    <= DEBOUNCE_RST;
			cfg_q.jam_timeout_ticks <= JAM_RST;
			cfg_q.max_coins         <= MAX_COINS_RST;
		end else if (wr) begin
			unique case (idx)
				REG_DEBOUNCE:  cfg_q.debounce_ticks    <= pwdata[CFG_TIMER_W-1:0];
				REG_JAM:       cfg_q.jam_timeout_ticks <= pwdata[CFG_TIMER_W-1:0];
				REG_MAX_COINS: cfg_q.max_coins         <= pwdata[COIN_W-1:0];
				REG_NONE:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE:  prdata = {16'd0, cfg_q.debounce_ticks};
			REG_JAM:       prdata = {16'd0, cfg_q.jam_timeout_ticks};
			REG_MAX_COINS: prdata = {24'd0, cfg_q.max_coins};
			REG_NONE:      prdata = 32'd0;
		endcase
	end

endmodule

/* src/chc_core.sv */
// Input register, session state and per-item result logic.
module chc_core
	import chc_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  mode_e      in_mode,
	input  logic [7:0] in_count,
	input  cfg_t       cfg,
	input  logic       room,
	output push_t      push
);

	localparam int CMP_W = (TIMER_BITS > CFG_TIMER_W) ? TIMER_BITS : CFG_TIMER_W;
	localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

	logic                  v_s1;
	mode_e                 mode_s1;
	logic [COIN_W-1:0]     count_s1;
	logic                  go;

	logic                  active_q, active_n;
	logic [COIN_W-1:0]     tgt_q, tgt_n;
	logic [COIN_W-1:0]     co_q, co_n;
	logic [TIMER_BITS-1:0] tsc_q, tsc_n, tsc_inc;
	logic [TIMER_BITS-1:0] tse_q, tse_n, tse_inc;
	logic [DUR_W-1:0]      st_q, st_n;

	logic [1:0]            n;
	event_e                ev0, ev1;
	err_e                  err0;
	logic                  ack0;
	logic [DUR_W-1:0]      dur1;

	assign go       = v_s1 && room;
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1  <= in_mode;
			count_s1 <= in_count;
		end
	end

	assign tsc_inc = (tsc_q == TMAX) ? TMAX : tsc_q + 1'b1;
	assign tse_inc = (tse_q == TMAX) ? TMAX : tse_q + 1'b1;

	always_comb begin
		active_n = active_q;
		tgt_n    = tgt_q;
		co_n     = co_q;
		tsc_n    = tsc_q;
		tse_n    = tse_q;
		st_n     = st_q;
		n        = 2'd0;
		ev0      = EV_ACK_OK;
		ev1      = EV_ACK_OK;
		err0     = ERR_NONE;
		ack0     = 1'b0;
		dur1     = '0;
		unique case (mode_s1)
			MODE_TICK: begin
				tse_n = tse_inc;
				if (active_q) begin
					st_n  = st_q + 1'b1;
					tsc_n = tsc_inc;
					if (CMP_W'(tsc_inc) >= CMP_W'(cfg.jam_timeout_ticks)) begin
						active_n = 1'b0;
						n        = 2'd1;
						ev0      = EV_FAIL;
						err0     = ERR_JAM;
					end
				end
			end
			MODE_EDGE: begin
				if (CMP_W'(tse_q) >= CMP_W'(cfg.debounce_ticks)) begin
					tse_n = '0;
					if (active_q) begin
						co_n  = co_q + 1'b1;
						tsc_n = '0;
						ev0   = EV_COIN;
						if (co_n >= tgt_q) begin
							active_n = 1'b0;
							n        = 2'd2;
							ev1      = EV_DONE;
							dur1     = st_q;
						end else begin
							n = 2'd1;
						end
					end
				end
			end
			MODE_REQ: begin
				n   = 2'd1;
				ev0 = EV_ACK_REJ;
				if (active_q) begin
					err0 = ERR_BUSY;
				end else if (count_s1 == '0 || count_s1 > cfg.max_coins) begin
					err0 = ERR_COUNT;
				end else begin
					active_n = 1'b1;
					tgt_n    = count_s1;
					co_n     = '0;
					tsc_n    = '0;
					st_n     = '0;
					ev0      = EV_ACK_OK;
				end
			end
			MODE_STOP: begin
				if (active_q) begin
					active_n = 1'b0;
					n        = 2'd2;
					ev0      = EV_FAIL;
					err0     = ERR_STOP;
					ev1      = EV_ACK_OK;
				end else begin
					n    = 2'd1;
					ack0 = 1'b1;
				end
			end
		endcase
	end

	// Results report the state as it stands after this item.
	always_comb begin
		push.cnt = go ? n : 2'd0;
		push.r0.event_res   = ev0;
		push.r0.ack_for     = ack0;
		push.r0.error_code  = err0;
		push.r0.dispensed   = co_n;
		push.r0.expected    = tgt_n;
		push.r0.sess_len    = '0;
		push.r0.motor_on    = active_n;
		push.r0.last        = (n == 2'd1);
		push.r1.event_res   = ev1;
		push.r1.ack_for     = (mode_s1 == MODE_STOP);
		push.r1.error_code  = ERR_NONE;
		push.r1.dispensed   = co_n;
		push.r1.expected    = tgt_n;
		push.r1.sess_len    = dur1;
		push.r1.motor_on    = active_n;
		push.r1.last        = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			tgt_q    <= '0;
			co_q     <= '0;
			tsc_q    <= '0;
			tse_q    <= '0;
			st_q     <= '0;
		end else if (go) begin
			active_q <= active_n;
			tgt_q    <= tgt_n;
			co_q     <= co_n;
			tsc_q    <= tsc_n;
			tse_q    <= tse_n;
			st_q     <= st_n;
		end
	end

	a_coins_below_target: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (co_q < tgt_q))
		else $error("coin count reached target inside a running session");

	a_stop_ends_session: assert property (@(posedge clk) disable iff (!arst_n)
		(go && mode_s1 == MODE_STOP) |=> !active_q)
		else $error("session still running after stop");

	a_done_pairs_coin: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt == 2'd2 && push.r1.event_res == EV_DONE) |->
		(push.r0.event_res == EV_COIN && !push.r0.motor_on))
		else $error("session done not preceded by its coin result");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!room |-> (push.cnt == 2'd0))
		else $error("results pushed without queue room");

endmodule

/* src/chc_outq.sv */
// Four-entry result queue that takes up to two results a cycle.
module chc_outq
	import chc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t       mem [4];
	logic [1:0] head_q;
	logic [2:0] cnt_q;
	logic [1:0] tail;
	logic       pop;

	assign tail      = head_q + cnt_q[1:0];
	assign out_valid = (cnt_q != 3'd0);
	assign out_res   = mem[head_q];
	assign pop       = out_valid && out_ready;
	assign room      = (cnt_q <= 3'd2);

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem[tail] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem[tail + 2'd1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (pop) begin
				head_q <= head_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push.cnt} - {2'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(push.cnt != 2'd0) |-> ({1'b0, cnt_q} + {2'b0, push.cnt} <= 4'd4))
		else $error("push exceeds free entries");

	a_head_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(head_q)))
		else $error("stalled result moved");

endmodule

/* src/coin_hopper_dispense_controller.sv */
// Top level of the coin hopper dispense controller.
//
//  channel   dir  handshake           payload
//  s_axis    in   s_tvalid/s_tready   s_tuser = mode, s_tdata = coin_count
//  m_axis    out  m_tvalid/m_tready   m_tuser, m_tdata, m_tlast = last
//  apb       in   psel/penable        paddr 0x0 debounce, 0x4 jam timeout, 0x8 max coins
//
// Each item is held in the input register and makes one pass through the
// session logic, which writes up to two results into a four-entry queue.
// An item can be taken every cycle; the rate is set by the result channel,
// which drains one result a cycle, so items that give two results halve it.
// The input stage holds its item while fewer than two queue entries are free.
// Reset clears the session state and loads the register defaults.
module coin_hopper_dispense_controller
	import chc_pkg::*;
#(
	parameter int TIMER_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] coin_count
	input  logic [1:0]  s_tuser,   // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	// [2:0] error_code, [10:3] dispensed, [18:11] expected,
	// [50:19] sess_len, [51] motor_on, [55:52] zero
	output logic [55:0] m_tdata,
	output logic [3:0]  m_tuser,   // [2:0] event_res, [3] ack_for
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t  cfg;
	push_t push;
	logic  room;
	res_t  res;

	chc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Session logic: debounce, coin counting, jam timer and request checks.
	chc_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (mode_e'(s_tuser)),
		.in_count (s_tdata),
		.cfg      (cfg),
		.room     (room),
		.push     (push)
	);

	// Queue decouples the two-result items from the output handshake.
	chc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {4'd0, res.motor_on, res.sess_len, res.expected,
		res.dispensed, res.error_code};
	assign m_tuser = {res.ack_for, res.event_res};
	assign m_tlast = res.last;

endmodule

/* tb/tb_coin_hopper_dispense_controller.sv */
// Self-checking testbench for the coin hopper dispense controller.
`timescale 1ns / 1ps

module tb_coin_hopper_dispense_controller;
	import chc_pkg::*;

	// Generous: the slowest legal run stays far below this.
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	// Cycles to let pass after the last result: input register, session logic, result queue.
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam logic [CFG_TIMER_W-1:0] TIMER_MAX = '1;

	// Session predictor plus the queue of events still owed by the block.
	class hopper_scoreboard;
		logic [CFG_TIMER_W-1:0] debounce;
		logic [CFG_TIMER_W-1:0] jam_limit;
		logic [COIN_W-1:0]      max_coins;

		logic                   running;
		logic [COIN_W-1:0]      target;
		logic [COIN_W-1:0]      coins;
		logic [CFG_TIMER_W-1:0] since_coin;
		logic [CFG_TIMER_W-1:0] since_edge;
		logic [DUR_W-1:0]       sess_ticks;

		res_t owed_events[$];

		int unsigned errors;
		int unsigned checked;
		int unsigned n_coin, n_done, n_jam, n_stop, n_reject;

		function new();
			debounce   = DEBOUNCE_RST;
			jam_limit  = JAM_RST;
			max_coins  = MAX_COINS_RST;
			running    = 1'b0;
			target     = '0;
			coins      = '0;
			since_coin = '0;
			since_edge = '0;
			sess_ticks = '0;
			errors     = 0;
			checked    = 0;
			n_coin     = 0;
			n_done     = 0;
			n_jam      = 0;
			n_stop     = 0;
			n_reject   = 0;
		endfunction

		function void write_reg(reg_idx_e idx, logic [31:0] val);
			case (idx)
				REG_DEBOUNCE:  debounce  = val[CFG_TIMER_W-1:0];
				REG_JAM:       jam_limit = val[CFG_TIMER_W-1:0];
				REG_MAX_COINS: max_coins = val[COIN_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [CFG_TIMER_W-1:0] bump(logic [CFG_TIMER_W-1:0] v);
			return (v == TIMER_MAX) ? v : v + 1'b1;
		endfunction

		// Queue one event, stamped with the session state as it stands now.
		function void owe(event_e ev, logic stop_ack, err_e err, logic [DUR_W-1:0] dur,
				logic fin);
			res_t r;
			r.event_res   = ev;
			r.ack_for     = stop_ack;
			r.error_code  = err;
			r.dispensed   = coins;
			r.expected    = target;
			r.sess_len    = dur;
			r.motor_on    = running;
			r.last        = fin;
			owed_events.push_back(r);
		endfunction

		// Advance the session by one accepted command; return 0 if the block ignores it.
		function bit take_command(mode_e m, logic [COIN_W-1:0] cnt);
			case (m)
				MODE_TICK: begin
					since_edge = bump(since_edge);
					if (running) begin
						sess_ticks = sess_ticks + 1'b1;
						since_coin = bump(since_coin);
						if (since_coin >= jam_limit) begin
							running = 1'b0;
							owe(EV_FAIL, 1'b0, ERR_JAM, '0, 1'b1);
						end
					end
				end
				MODE_EDGE: begin
					if (since_edge < debounce)
						return 1'b0;
					since_edge = '0;
					if (running) begin
						coins      = coins + 1'b1;
						since_coin = '0;
						if (coins >= target) begin
							running = 1'b0;
							owe(EV_COIN, 1'b0, ERR_NONE, '0, 1'b0);
							owe(EV_DONE, 1'b0, ERR_NONE, sess_ticks, 1'b1);
						end else begin
							owe(EV_COIN, 1'b0, ERR_NONE, '0, 1'b1);
						end
					end
				end
				MODE_REQ: begin
					if (running) begin
						owe(EV_ACK_REJ, 1'b0, ERR_BUSY, '0, 1'b1);
					end else if (cnt == '0 || cnt > max_coins) begin
						owe(EV_ACK_REJ, 1'b0, ERR_COUNT, '0, 1'b1);
					end else begin
						running    = 1'b1;
						target     = cnt;
						coins      = '0;
						since_coin = '0;
						sess_ticks = '0;
						owe(EV_ACK_OK, 1'b0, ERR_NONE, '0, 1'b1);
					end
				end
				default: begin
					if (running) begin
						running = 1'b0;
						owe(EV_FAIL, 1'b0, ERR_STOP, '0, 1'b0);
					end
					owe(EV_ACK_OK, 1'b1, ERR_NONE, '0, 1'b1);
				end
			endcase
			return 1'b1;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 40)
				$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		endtask

		task check_result(res_t got);
			res_t want;
			if (owed_events.size() == 0) begin
				report("result with nothing owed, event_res", got.event_res, 0);
				return;
			end
			want = owed_events.pop_front();
			checked++;
			if (got.event_res !== want.event_res)
				report("event_res", got.event_res, want.event_res);
			if (got.ack_for !== want.ack_for)
				report("ack_for", got.ack_for, want.ack_for);
			if (got.error_code !== want.error_code)
				report("error_code", got.error_code, want.error_code);
			if (got.dispensed !== want.dispensed)
				report("dispensed", got.dispensed, want.dispensed);
			if (got.expected !== want.expected)
				report("expected", got.expected, want.expected);
			if (got.sess_len !== want.sess_len)
				report("sess_len", got.sess_len, want.sess_len);
			if (got.motor_on !== want.motor_on)
				report("motor_on", got.motor_on, want.motor_on);
			if (got.last !== want.last)
				report("last", got.last, want.last);
			case (want.event_res)
				EV_COIN:    n_coin++;
				EV_DONE:    n_done++;
				EV_ACK_REJ: n_reject++;
				EV_FAIL: begin
					if (want.error_code == ERR_JAM)
						n_jam++;
					else
						n_stop++;
				end
				default: ;
			endcase
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] coin_count
	logic [1:0]  s_tuser = '0;   // [1:0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [2:0] error_code, [10:3] dispensed, [18:11] expected,
	// [50:19] sess_len, [51] motor_on, [55:52] zero
	logic [55:0] m_tdata;
	logic [3:0]  m_tuser;        // [2:0] event_res, [3] ack_for
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	hopper_scoreboard sb;

	// Percent chance that an item or a result slot starts an idle burst.
	int unsigned gap_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	coin_hopper_dispense_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Hold off results in random bursts; stall_pct of zero keeps ready high.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Unpack each accepted result and compare it with the oldest owed event.
	always @(posedge clk) begin : watch_results
		res_t seen;
		if (arst_n && m_tvalid && m_tready) begin
			seen.event_res   = event_e'(m_tuser[2:0]);
			seen.ack_for     = m_tuser[3];
			seen.error_code  = err_e'(m_tdata[2:0]);
			seen.dispensed   = m_tdata[10:3];
			seen.expected    = m_tdata[18:11];
			seen.sess_len    = m_tdata[50:19];
			seen.motor_on    = m_tdata[51];
			seen.last        = m_tlast;
			sb.check_result(seen);
		end
	end

	// Offer one item, optionally after an idle burst; advance the predictor once it is taken.
	// Call and return at a falling edge.
	task automatic send_item(input mode_e m, input logic [7:0] cnt);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= m;
		s_tdata  <= cnt;
		do @(posedge clk); while (!s_tready);
		void'(sb.take_command(m, cnt));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_ticks(input int unsigned n);
		repeat (n) send_item(MODE_TICK, 8'($urandom));
	endtask

	// Drop valid, wait for every owed event, then let the pipeline empty out.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.owed_events.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// APB write: setup cycle, access cycle, then an idle bus cycle.
	task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.write_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Upper pwdata bits are junk; only the register width must land.
	task automatic set_cfg(input logic [15:0] deb, input logic [15:0] jam,
			input logic [7:0] maxc);
		reg_write(REG_DEBOUNCE, {16'($urandom), deb});
		reg_write(REG_JAM, {16'($urandom), jam});
		reg_write(REG_MAX_COINS, {24'($urandom), maxc});
	endtask

	// Mostly well-formed sessions with random timing, salted with bounces, busy requests,
	// stops, long coin gaps and plain noise.
	task automatic mixed_traffic(input int unsigned quota);
		int unsigned stop_at;
		int unsigned goal;
		int unsigned top;
		int unsigned deb_win;
		int unsigned jam_gap;
		int unsigned k;
		stop_at = items_sent + quota;
		while (items_sent < stop_at) begin
			if ($urandom_range(99) < 15) begin
				send_item(mode_e'($urandom_range(0, 3)), 8'($urandom));
			end else begin
				top     = (sb.max_coins == 0) ? 1 : sb.max_coins;
				deb_win = (sb.debounce < 40) ? sb.debounce + 1 : 40;
				jam_gap = (sb.jam_limit < 60) ? sb.jam_limit + 1 : 60;
				if ($urandom_range(9) == 0)
					goal = $urandom_range(0, 255);
				else
					goal = $urandom_range(1, (top < 6) ? top : 6);
				send_item(MODE_REQ, goal[7:0]);
				for (k = 0; k < goal && k < 10; k++) begin
					case ($urandom_range(19))
						0: send_item(MODE_STOP, 8'($urandom));
						1: send_item(MODE_REQ, 8'($urandom));
						2: send_ticks(jam_gap);
						default: ;
					endcase
					send_ticks($urandom_range(0, deb_win));
					send_item(MODE_EDGE, 8'($urandom));
					if ($urandom_range(5) == 0)
						send_item(MODE_EDGE, 8'($urandom));
				end
			end
		end
	endtask

	task automatic run_phase(input logic [15:0] deb, input logic [15:0] jam,
			input logic [7:0] maxc, input int unsigned gap, input int unsigned stall,
			input int unsigned quota);
		settle();
		set_cfg(deb, jam, maxc);
		gap_pct   = gap;
		stall_pct = stall;
		mixed_traffic(quota);
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset defaults: early-window edge, idle stop, bad counts, busy, abort.
		gap_pct   = 25;
		stall_pct = 25;
		send_item(MODE_EDGE, 8'hFF);
		send_item(MODE_STOP, 8'h00);
		send_item(MODE_REQ, 8'd0);
		send_item(MODE_REQ, 8'd201);
		send_item(MODE_REQ, 8'd200);
		send_item(MODE_REQ, 8'd255);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_STOP, 8'hFF);

		// Short windows: completion, bounce, full-count request, jam, idle edge.
		settle();
		set_cfg(16'd1, 16'd3, 8'd255);
		reg_write(REG_NONE, $urandom);
		send_item(MODE_REQ, 8'd2);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_REQ, 8'd255);
		send_ticks(4);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_EDGE, 8'h00);

		// Zero jam timeout and zero coin limit.
		settle();
		set_cfg(16'd0, 16'd0, 8'd0);
		send_item(MODE_REQ, 8'd1);
		settle();
		reg_write(REG_MAX_COINS, 32'd1);
		send_item(MODE_REQ, 8'd1);
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REQ, 8'd2);

		// Widest timers: every edge falls inside the window, stop aborts the session.
		settle();
		set_cfg(16'hFFFF, 16'hFFFF, 8'd255);
		gap_pct = 0;
		send_item(MODE_REQ, 8'd3);
		send_item(MODE_EDGE, 8'h00);
		send_ticks(20);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_EDGE, 8'h00);
		send_item(MODE_STOP, 8'h00);

		run_phase(16'd0, 16'd1, 8'd255, 20, 20, 195);
		run_phase(16'd1, 16'd8, 8'd5, 40, 10, 195);
		run_phase(16'd3, 16'd20, 8'($urandom_range(1, 255)), 10, 40, 195);
		run_phase(16'($urandom_range(0, 4)), 16'($urandom_range(2, 30)),
			8'($urandom_range(1, 255)), 30, 30, 195);
		run_phase(16'd2, 16'hFFFF, 8'd1, 15, 5, 195);
		// Closing stretch runs at full rate on both sides.
		run_phase(16'd0, 16'd10, 8'd255, 0, 0, 195);
		settle();

		$display("Sent %0d items over several register settings; %0d results checked.",
			items_sent, sb.checked);
		$display("Sessions: %0d done, %0d jammed, %0d stopped; %0d coins, %0d refusals.",
			sb.n_done, sb.n_jam, sb.n_stop, sb.n_coin, sb.n_reject);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
